/* sv/sib_pkg.sv */
`default_nettype none
package sib_pkg;

  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned VALUE_W = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 6;

  localparam logic [FUNC_W-1:0]  FUNC_INSERT = 1'b0;
  localparam logic [FUNC_W-1:0]  FUNC_READ   = 1'b1;
  localparam logic [VALUE_W-1:0] SENTINEL    = 4'hF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRCH,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // compare and shift the cells
    logic step;   // one bit of the slot search
    logic fin;    // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_ok;     // captured item is an insert with room left
    logic srch_last;  // current search step is the last one
  } sts_t;

endpackage
`default_nettype wire

/* sv/sorted_insertion_buffer_core.sv */
// sorted_insertion_buffer_core
// Holds up to DEPTH 4-bit values in ascending order in a row of cells.
// Input channel (in_valid / in_stall): func selects insert (value is placed
// in front of the first stored value that is strictly greater) or read.
// Output channel (out_valid / out_stall): one result item per input item:
// accepted, position of the last stored insert, count, and the value held
// at that position.
// Timing: the controller takes one item at a time. Every item passes through
// the compare/shift state, where a stored insert compares and shifts the cells
// in parallel, and then the final state, which loads the output register.
// A stored insert also runs, between those two, a bit-serial search of the
// compare vector, one slot-index bit per cycle, to encode the insert position.
// The result sits in an output register, so the next item is accepted while
// a result is still waiting; a stalled result holds until taken, and the
// following item then waits in the final state.
// Reset (rst, synchronous): all cells read 15, the fill level and the remembered
// position are 0, no result is pending.
`default_nettype none
module sorted_insertion_buffer_core
  import sib_pkg::*;
#(
  parameter int unsigned DEPTH = 32
)
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [FUNC_W-1:0]   func,
  input  wire  [VALUE_W-1:0]  value,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic                accepted,
  output logic [POS_W-1:0]    position,
  output logic [COUNT_W-1:0]  count,
  output logic [VALUE_W-1:0]  read_value
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: idle, compare/shift, slot search, result hand-off
  sib_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // cells, fill level, remembered slot and the output register
  sib_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .func       (func),
    .value      (value),
    .accepted   (accepted),
    .position   (position),
    .count      (count),
    .read_value (read_value)
  );

  // one item in flight: after an accept the input stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in flight");

  // a stored insert always leaves at least one value
  a_acc_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted && (DEPTH < 64) |-> count != '0)
    else $error("accepted insert with zero count");

  // remembered slot lies inside the filled range
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted && (DEPTH <= 32) |-> COUNT_W'(position) < count)
    else $error("position outside filled range");

endmodule
`default_nettype wire

/* sv/sib_ctrl.sv */
`default_nettype none
module sib_ctrl
  import sib_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire  out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid & out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.ins_ok ? ST_SRCH : ST_FIN;
      end
      ST_SRCH: begin
        cmd.step = 1'b1;
        if (sts.srch_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.fin        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/sib_dp.sv */
`default_nettype none
module sib_dp
  import sib_pkg::*;
#(
  parameter int unsigned DEPTH = 32
)
(
  input  wire                 clk,
  input  wire                 rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  wire  [FUNC_W-1:0]   func,
  input  wire  [VALUE_W-1:0]  value,
  output logic                accepted,
  output logic [POS_W-1:0]    position,
  output logic [COUNT_W-1:0]  count,
  output logic [VALUE_W-1:0]  read_value
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot index
  localparam int unsigned CW = $clog2(DEPTH + 1);                // fill level
  localparam int unsigned BW = $clog2(PW + 1);                   // search bit index

  logic [VALUE_W-1:0] cells [DEPTH];
  logic [DEPTH-1:0]   therm;       // 1 from the insert slot upward
  logic [DEPTH-1:0]   mv;
  logic [CW-1:0]      fill;
  logic [PW-1:0]      last_pos;
  logic [VALUE_W-1:0] rd_val;
  logic [FUNC_W-1:0]  func_r;
  logic [VALUE_W-1:0] val_r;
  logic               acc_flag;
  logic [PW-1:0]      acc;
  logic [BW-1:0]      bit_idx;

  logic [PW:0]        cand;
  logic [PW:0]        cand_m1;
  logic               cand_ok;

  assign sts.ins_ok    = (func_r == FUNC_INSERT) && (fill < CW'(DEPTH));
  assign sts.srch_last = (bit_idx == '0);

  // per-cell compare: the new value lands in front of this cell or above it
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      mv[i] = (CW'(i) >= fill) || (val_r < cells[i]);
    end
  end

  // successive approximation over the thermometer: slot = number of zeros
  always_comb begin
    cand    = {1'b0, acc} | ((PW + 1)'(1) << bit_idx);
    cand_m1 = cand - (PW + 1)'(1);
    cand_ok = (cand <= (PW + 1)'(DEPTH)) && !therm[cand_m1[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells[i] <= SENTINEL;
      end
      fill     <= '0;
      last_pos <= '0;
      rd_val   <= SENTINEL;
    end else begin
      if (cmd.exec && sts.ins_ok) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (i > 0 && mv[(i > 0) ? i - 1 : 0]) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end else if (mv[i]) begin
            cells[i] <= val_r;
          end
        end
        fill   <= fill + CW'(1);
        rd_val <= val_r;
      end
      if (cmd.step && cand_ok) begin
        last_pos <= cand[PW-1:0];
      end else if (cmd.step && bit_idx == BW'(PW - 1)) begin
        last_pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      val_r   <= value;
      acc     <= '0;
      bit_idx <= BW'(PW - 1);
    end
    if (cmd.exec) begin
      acc_flag <= sts.ins_ok;
      therm    <= mv;
    end
    if (cmd.step) begin
      if (cand_ok) begin
        acc <= cand[PW-1:0];
      end
      bit_idx <= bit_idx - BW'(1);
    end
    if (cmd.fin) begin
      accepted   <= acc_flag;
      position   <= POS_W'(last_pos);
      count      <= COUNT_W'(fill);
      read_value <= rd_val;
    end
  end

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for sorted_insertion_buffer_core.
// A directed table runs first, then random items. Every accepted item is fed
// to a shadow copy of the sorted buffer, and its expected report (the table's for
// typed rows, else the predicted one) is queued. Each report taken from the
// output channel is checked against the oldest queued report.
// Reset is applied once, so the buffer fills only one time in the whole run.
// Inserts are kept sparse until the buffer is full. After that, rejected
// inserts and reads make up the rest of the run.
module tb;
  import sib_pkg::*;

  localparam int unsigned DEPTH      = 32;
  localparam int          N_PLAN     = 16;
  localparam int          N_RANDOM   = 834;
  localparam int          CALM_TAIL  = 120;    // last random items run with no idling
  localparam int          HOLD_AT    = 300;    // random item that starts the long output hold
  localparam int          HOLD_LEN   = 400;
  localparam int          DRAIN_AT   = 520;    // random item where the sender waits for all reports
  localparam int          TAIL_WAIT  = 24;     // longer than the slowest insert
  localparam int          LIMIT      = 200000;

  // One report, as the output channel carries it.
  typedef struct packed {
    logic               acc;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] cnt;
    logic [VALUE_W-1:0] rv;
  } buf_report_t;

  // One row of the directed table. typed = 1: the report below is the expected one.
  typedef struct packed {
    logic [FUNC_W-1:0]  f;
    logic [VALUE_W-1:0] v;
    logic               typed;
    buf_report_t        rep;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic               accepted;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] count;
  logic [VALUE_W-1:0] read_value;

  sorted_insertion_buffer_core #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .position   (position),
    .count      (count),
    .read_value (read_value)
  );

  // Shadow of the buffer state
  logic [VALUE_W-1:0] shadow_cells [DEPTH];
  int unsigned        shadow_fill;
  int unsigned        shadow_pos;

  buf_report_t        expected_reports [$];
  plan_row_t          plan [N_PLAN];

  int  errors;
  int  n_stored, n_rejected, n_reads, n_checked;
  int  cycle_count;
  bit  calm;       // no idling on either side
  bit  hold_req;   // sender asks the receiver for one long hold

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-away guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still expected",
               cycle_count, expected_reports.size());
      $display("** sorted_insertion_buffer_core: FAILED **");
      $finish;
    end
  end

  // Apply one item to the shadow buffer; returns the report it causes.
  // An insert lands in front of the first strictly greater value, so equal
  // values keep their arrival order. Slots above the fill level stay 15.
  function automatic buf_report_t sort_insert_predict(logic [FUNC_W-1:0] f,
                                                      logic [VALUE_W-1:0] v);
    buf_report_t r;
    int unsigned slot;
    bit          found;
    r.acc = 1'b0;
    if (f == FUNC_INSERT && shadow_fill < DEPTH) begin
      slot  = shadow_fill;
      found = 1'b0;
      for (int unsigned k = 0; k < shadow_fill; k++) begin
        if (!found && v < shadow_cells[k]) begin
          slot  = k;
          found = 1'b1;
        end
      end
      for (int unsigned k = shadow_fill; k > slot; k--)
        shadow_cells[k] = shadow_cells[k-1];
      shadow_cells[slot] = v;
      shadow_pos  = slot;
      shadow_fill = shadow_fill + 1;
      r.acc = 1'b1;
      n_stored++;
    end else if (f == FUNC_INSERT) begin
      n_rejected++;
    end else begin
      n_reads++;
    end
    r.pos = shadow_pos[POS_W-1:0];
    r.cnt = shadow_fill[COUNT_W-1:0];
    r.rv  = shadow_cells[shadow_pos];
    return r;
  endfunction

  // Offer one item, hold it until taken, then queue its expected report.
  // Called at a falling edge, returns at a falling edge.
  task automatic offer_item(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                            logic typed, buf_report_t typed_rep);
    buf_report_t pred;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    func     = f;
    value    = v;
    do @(posedge clk); while (in_stall);
    pred = sort_insert_predict(f, v);
    expected_reports.push_back(typed ? typed_rep : pred);
    @(negedge clk);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Output checker: every report taken is matched to the oldest prediction.
  always @(posedge clk) begin
    buf_report_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected report: accepted %0d position %0d count %0d value %0d",
                 $time, accepted, position, count, read_value);
        errors++;
      end else begin
        exp_r = expected_reports.pop_front();
        check_field("accepted",   exp_r.acc, accepted);
        check_field("position",   exp_r.pos, position);
        check_field("count",      exp_r.cnt, count);
        check_field("read_value", exp_r.rv,  read_value);
        n_checked++;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request so the
  // block backs up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Sender: reset, directed table, random items, drain.
  initial begin
    buf_report_t        no_rep;
    logic [FUNC_W-1:0]  f;
    logic [VALUE_W-1:0] v;

    rst      = 1'b1;
    in_valid = 1'b0;
    func     = FUNC_INSERT;
    value    = '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    errors   = 0;
    n_stored = 0; n_rejected = 0; n_reads = 0; n_checked = 0;
    no_rep   = '0;
    for (int k = 0; k < DEPTH; k++) shadow_cells[k] = SENTINEL;
    shadow_fill = 0;
    shadow_pos  = 0;

    // Directed table. Typed rows: reads before any insert see the sentinel,
    // the first insert lands at 0, 0 goes in front, a second 15 goes after
    // the last one. The rest is left to the predictor (equal values, middle
    // slots, reads between inserts).
    plan[0]  = '{FUNC_READ,   4'd0,  1'b1, '{1'b0, 5'd0, 6'd0, 4'd15}};
    plan[1]  = '{FUNC_READ,   4'd15, 1'b1, '{1'b0, 5'd0, 6'd0, 4'd15}};
    plan[2]  = '{FUNC_INSERT, 4'd15, 1'b1, '{1'b1, 5'd0, 6'd1, 4'd15}};
    plan[3]  = '{FUNC_INSERT, 4'd0,  1'b1, '{1'b1, 5'd0, 6'd2, 4'd0}};
    plan[4]  = '{FUNC_INSERT, 4'd15, 1'b1, '{1'b1, 5'd2, 6'd3, 4'd15}};
    plan[5]  = '{FUNC_INSERT, 4'd7,  1'b0, no_rep};
    plan[6]  = '{FUNC_READ,   4'd0,  1'b0, no_rep};
    plan[7]  = '{FUNC_INSERT, 4'd7,  1'b0, no_rep};
    plan[8]  = '{FUNC_INSERT, 4'd0,  1'b0, no_rep};
    plan[9]  = '{FUNC_INSERT, 4'd8,  1'b0, no_rep};
    plan[10] = '{FUNC_INSERT, 4'd14, 1'b0, no_rep};
    plan[11] = '{FUNC_INSERT, 4'd1,  1'b0, no_rep};
    plan[12] = '{FUNC_READ,   4'd10, 1'b0, no_rep};
    plan[13] = '{FUNC_INSERT, 4'd5,  1'b0, no_rep};
    plan[14] = '{FUNC_INSERT, 4'd12, 1'b0, no_rep};
    plan[15] = '{FUNC_INSERT, 4'd3,  1'b0, no_rep};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i])
      offer_item(plan[i].f, plan[i].v, plan[i].typed, plan[i].rep);

    // Random part. Inserts stay sparse while there is room (one item in six),
    // so the fill-up spreads out; once full, inserts are rejected.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        in_valid = 1'b0;
        while (expected_reports.size() != 0) @(negedge clk);
      end
      if (shadow_fill < DEPTH)
        f = ($urandom_range(0, 5) == 0) ? FUNC_INSERT : FUNC_READ;
      else
        f = ($urandom_range(0, 1) == 0) ? FUNC_INSERT : FUNC_READ;
      if ($urandom_range(0, 4) == 0)
        v = $urandom_range(0, 1) ? SENTINEL : 4'd0;
      else
        v = VALUE_W'($urandom_range(0, 15));
      offer_item(f, v, 1'b0, no_rep);
    end
    in_valid = 1'b0;

    while (expected_reports.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);

    $display("covered %0d inserts stored, %0d inserts into a full buffer, %0d reads",
             n_stored, n_rejected, n_reads);
    $display("%0d reports checked, final fill %0d of %0d, %0d errors",
             n_checked, shadow_fill, DEPTH, errors);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("** sorted_insertion_buffer_core: PASSED **");
    end else begin
      $display("** sorted_insertion_buffer_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sib_pkg.sv
sv/sib_ctrl.sv
sv/sib_dp.sv
sv/sorted_insertion_buffer_core.sv
dv/tb.sv
